// File: src/trsl_pkg.sv
package trsl_pkg;

   localparam int QUO_W = 17;
   localparam int SLOPE_QW = 16;
   localparam int REM_W = 52;
   localparam int DEN_W = 34;
   localparam int SQ_W = 34;
   localparam int ROOT_STEPS = 17;

   // 0.001 in Q.16
   localparam logic [16:0] NEAR_LIM = 17'(65536 / 1000);
   localparam logic [33:0] ONE_SQ = 34'h1_0000_0000;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_NOINT = 2'd2;
   localparam logic [1:0] ST_NEAR  = 2'd3;

   typedef struct packed {
      logic signed [15:0] first_mic_x;
      logic signed [15:0] first_mic_y;
      logic signed [15:0] second_mic_x;
      logic signed [15:0] second_mic_y;
      logic signed [15:0] camera_x;
      logic signed [15:0] camera_y;
   } cfg_type;

   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [16:0]        c;
      logic [33:0]        c2;
      logic               busy;
   } geom_type;

   typedef struct packed {
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      logic [1:0]         status;
      logic signed [15:0] line_slope;
      logic signed [15:0] line_offset;
      logic               slope_undefined;
   } res_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
   } sqrt_type;

   function automatic div_type div_step(div_type d, logic [DEN_W-1:0] den, logic [4:0] sh);
      logic [REM_W-1:0] dsh;
      div_type r;
      dsh = {{(REM_W-DEN_W){1'b0}}, den} << sh;
      r = d;
      if (d.rem >= dsh) begin
         r.rem = d.rem - dsh;
         r.quo = d.quo | (QUO_W'(1) << sh);
      end
      return r;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type s, logic [4:0] k);
      logic [SQ_W-1:0] bitv;
      logic [SQ_W-1:0] trial;
      sqrt_type r;
      bitv = SQ_W'(1) << {k, 1'b0};
      trial = s.res + bitv;
      r = s;
      if (s.rem >= trial) begin
         r.rem = s.rem - trial;
         r.res = (s.res >> 1) + bitv;
      end else begin
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: src/trsl_base.sv
module trsl_base (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  trsl_pkg::cfg_type cfg,
   output trsl_pkg::geom_type geom
);
   import trsl_pkg::*;

   typedef enum logic [2:0] {
      LOAD, SQUARE, ROOT, FINAL, SQUARE_C, IDLE
   } state_type;

   state_type          state_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic [16:0]        c_ff;
   logic [33:0]        c2_ff;
   sqrt_type           sq_ff;
   logic [4:0]         k_ff;
   logic signed [34:0] sum_in;

   assign sum_in = dx_ff * dx_ff + dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
      end else if (start) begin
         state_ff <= LOAD;
      end else begin
         unique case (state_ff)
            LOAD: begin
               dx_ff <= 17'(cfg.second_mic_x) - 17'(cfg.first_mic_x);
               dy_ff <= 17'(cfg.second_mic_y) - 17'(cfg.first_mic_y);
               state_ff <= SQUARE;
            end
            SQUARE: begin
               sq_ff.rem <= sum_in[33:0];
               sq_ff.res <= '0;
               k_ff <= 5'(ROOT_STEPS - 1);
               state_ff <= ROOT;
            end
            ROOT: begin
               sq_ff <= sqrt_step(sq_ff, k_ff);
               if (k_ff == 5'd0) begin
                  state_ff <= FINAL;
               end else begin
                  k_ff <= k_ff - 5'd1;
               end
            end
            FINAL: begin
               c_ff <= sq_ff.res[16:0];
               state_ff <= SQUARE_C;
            end
            SQUARE_C: begin
               c2_ff <= c_ff * c_ff;
               state_ff <= IDLE;
            end
            IDLE: begin
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= LOAD;
            end
         endcase
      end
   end

   assign geom.dx   = dx_ff;
   assign geom.dy   = dy_ff;
   assign geom.c    = c_ff;
   assign geom.c2   = c2_ff;
   assign geom.busy = (state_ff != IDLE);

   a_c2_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> (c2_ff == c_ff * c_ff))
      else $error("baseline square out of step with baseline");

endmodule

// File: src/trsl_core.sv
module trsl_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [14:0]        range_to_first,
   input  logic [14:0]        range_to_second,
   input  trsl_pkg::cfg_type  cfg,
   input  trsl_pkg::geom_type geom,
   output logic               out_valid,
   output trsl_pkg::res_type  out_res
);
   import trsl_pkg::*;

   localparam int CDIV0 = 3;
   localparam int COSF  = CDIV0 + QUO_W;
   localparam int COS2  = COSF + 1;
   localparam int SQI   = COS2 + 1;
   localparam int SQ0   = SQI + 1;
   localparam int SINF  = SQ0 + ROOT_STEPS;
   localparam int MUL   = SINF + 1;
   localparam int TSUM  = MUL + 1;
   localparam int PMUL  = TSUM + 1;
   localparam int XYI   = PMUL + 1;
   localparam int XY0   = XYI + 1;
   localparam int XYF   = XY0 + QUO_W;
   localparam int DDS   = XYF + 1;
   localparam int SLI   = DDS + 1;
   localparam int SL0   = SLI + 1;
   localparam int SLF   = SL0 + SLOPE_QW;
   localparam int OPR   = SLF + 1;
   localparam int OFS   = OPR + 1;
   localparam int NSTG  = OFS + 1;

   typedef struct packed {
      logic [14:0]        a;
      logic [14:0]        b;
      logic [29:0]        a2;
      logic [29:0]        b2;
      logic [31:0]        ac;
      logic               nneg;
      logic [34:0]        nmag;
      logic [DEN_W-1:0]   den;
      logic [1:0]         status;
      div_type            dv0;
      div_type            dv1;
      logic signed [17:0] cosq;
      logic               near;
      logic [33:0]        cos2;
      sqrt_type           sq;
      logic [16:0]        sinq;
      logic signed [35:0] m0;
      logic signed [35:0] m1;
      logic signed [35:0] m2;
      logic signed [35:0] m3;
      logic signed [35:0] tx;
      logic signed [35:0] ty;
      logic signed [51:0] px;
      logic signed [51:0] py;
      logic               negx;
      logic               negy;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [16:0] ddx;
      logic signed [16:0] ddy;
      logic               undef;
      logic               ovf;
      logic               sneg;
      logic signed [15:0] slope;
      logic signed [31:0] prod;
      logic signed [15:0] offset;
   } item_type;

   item_type          pipe_ff [NSTG];
   item_type          pipe_in [NSTG];
   logic [NSTG-1:0]   val_ff;

   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      if (k == 0) begin : g_in
         always_comb begin
            pipe_in[k] = '0;
            pipe_in[k].a = range_to_first;
            pipe_in[k].b = range_to_second;
         end
      end else if (k == 1) begin : g_sq
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].a2 = {15'd0, pipe_ff[k-1].a} * {15'd0, pipe_ff[k-1].a};
            pipe_in[k].b2 = {15'd0, pipe_ff[k-1].b} * {15'd0, pipe_ff[k-1].b};
            pipe_in[k].ac = {17'd0, pipe_ff[k-1].a} * {15'd0, geom.c};
         end
      end else if (k == 2) begin : g_num
         always_comb begin
            logic signed [35:0] num;
            logic signed [35:0] nn;
            pipe_in[k] = pipe_ff[k-1];
            num = $signed({6'd0, pipe_ff[k-1].a2}) + $signed({2'd0, geom.c2})
                  - $signed({6'd0, pipe_ff[k-1].b2});
            nn = -num;
            pipe_in[k].nneg = num[35];
            pipe_in[k].nmag = num[35] ? nn[34:0] : num[34:0];
            pipe_in[k].den = {1'b0, pipe_ff[k-1].ac, 1'b0};
            if (pipe_ff[k-1].a == 15'd0 || geom.c == 17'd0) begin
               pipe_in[k].status = ST_ZERO;
            end else if (pipe_in[k].nmag > {1'b0, pipe_in[k].den}) begin
               pipe_in[k].status = ST_NOINT;
            end else begin
               pipe_in[k].status = ST_OK;
            end
            pipe_in[k].dv0.rem = {1'b0, pipe_in[k].nmag, 16'd0};
            pipe_in[k].dv0.quo = '0;
         end
      end else if (k >= CDIV0 && k < COSF) begin : g_cdiv
         localparam int SH = QUO_W - 1 - (k - CDIV0);
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].dv0 = div_step(pipe_ff[k-1].dv0, pipe_ff[k-1].den, 5'(SH));
         end
      end else if (k == COSF) begin : g_cosf
         always_comb begin
            logic signed [17:0] q;
            pipe_in[k] = pipe_ff[k-1];
            q = $signed({1'b0, pipe_ff[k-1].dv0.quo});
            pipe_in[k].cosq = pipe_ff[k-1].nneg ? -q : q;
            pipe_in[k].near = (pipe_ff[k-1].dv0.quo <= NEAR_LIM);
         end
      end else if (k == COS2) begin : g_cos2
         always_comb begin
            logic signed [35:0] cc;
            pipe_in[k] = pipe_ff[k-1];
            cc = pipe_ff[k-1].cosq * pipe_ff[k-1].cosq;
            pipe_in[k].cos2 = cc[33:0];
         end
      end else if (k == SQI) begin : g_sqi
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].sq.rem = ONE_SQ - pipe_ff[k-1].cos2;
            pipe_in[k].sq.res = '0;
         end
      end else if (k >= SQ0 && k < SINF) begin : g_root
         localparam int KB = ROOT_STEPS - 1 - (k - SQ0);
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].sq = sqrt_step(pipe_ff[k-1].sq, 5'(KB));
         end
      end else if (k == SINF) begin : g_sinf
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].sinq = pipe_ff[k-1].sq.res[16:0];
            if (pipe_ff[k-1].status == ST_OK &&
                (pipe_ff[k-1].near || pipe_in[k].sinq <= NEAR_LIM)) begin
               pipe_in[k].status = ST_NEAR;
            end
         end
      end else if (k == MUL) begin : g_mul
         always_comb begin
            logic signed [17:0] s;
            pipe_in[k] = pipe_ff[k-1];
            s = $signed({1'b0, pipe_ff[k-1].sinq});
            pipe_in[k].m0 = geom.dx * pipe_ff[k-1].cosq;
            pipe_in[k].m1 = geom.dy * s;
            pipe_in[k].m2 = geom.dy * pipe_ff[k-1].cosq;
            pipe_in[k].m3 = geom.dx * s;
         end
      end else if (k == TSUM) begin : g_tsum
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].tx = pipe_ff[k-1].m0 + pipe_ff[k-1].m1;
            pipe_in[k].ty = pipe_ff[k-1].m2 - pipe_ff[k-1].m3;
         end
      end else if (k == PMUL) begin : g_pmul
         always_comb begin
            logic signed [15:0] sa;
            pipe_in[k] = pipe_ff[k-1];
            sa = $signed({1'b0, pipe_ff[k-1].a});
            pipe_in[k].px = pipe_ff[k-1].tx * sa;
            pipe_in[k].py = pipe_ff[k-1].ty * sa;
         end
      end else if (k == XYI) begin : g_xyi
         always_comb begin
            logic [51:0] mx;
            logic [51:0] my;
            pipe_in[k] = pipe_ff[k-1];
            mx = pipe_ff[k-1].px[51] ? 52'(-pipe_ff[k-1].px) : 52'(pipe_ff[k-1].px);
            my = pipe_ff[k-1].py[51] ? 52'(-pipe_ff[k-1].py) : 52'(pipe_ff[k-1].py);
            pipe_in[k].negx = pipe_ff[k-1].px[51];
            pipe_in[k].negy = pipe_ff[k-1].py[51];
            pipe_in[k].dv0.rem = {16'd0, mx[51:16]};
            pipe_in[k].dv0.quo = '0;
            pipe_in[k].dv1.rem = {16'd0, my[51:16]};
            pipe_in[k].dv1.quo = '0;
            pipe_in[k].den = {17'd0, geom.c};
         end
      end else if (k >= XY0 && k < XYF) begin : g_xydiv
         localparam int SH = QUO_W - 1 - (k - XY0);
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].dv0 = div_step(pipe_ff[k-1].dv0, pipe_ff[k-1].den, 5'(SH));
            pipe_in[k].dv1 = div_step(pipe_ff[k-1].dv1, pipe_ff[k-1].den, 5'(SH));
         end
      end else if (k == XYF) begin : g_xyf
         always_comb begin
            logic signed [17:0] qx;
            logic signed [17:0] qy;
            logic signed [31:0] vx;
            logic signed [31:0] vy;
            pipe_in[k] = pipe_ff[k-1];
            qx = $signed({1'b0, pipe_ff[k-1].dv0.quo});
            qy = $signed({1'b0, pipe_ff[k-1].dv1.quo});
            if (pipe_ff[k-1].negx) begin
               qx = -qx;
            end
            if (pipe_ff[k-1].negy) begin
               qy = -qy;
            end
            vx = 32'(cfg.first_mic_x) + 32'(qx);
            vy = 32'(cfg.first_mic_y) + 32'(qy);
            if (pipe_ff[k-1].status == ST_OK) begin
               pipe_in[k].sx = sat16(vx);
               pipe_in[k].sy = sat16(vy);
            end else begin
               pipe_in[k].sx = '0;
               pipe_in[k].sy = '0;
            end
         end
      end else if (k == DDS) begin : g_dds
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].ddx = 17'(cfg.camera_x) - 17'(pipe_ff[k-1].sx);
            pipe_in[k].ddy = 17'(cfg.camera_y) - 17'(pipe_ff[k-1].sy);
         end
      end else if (k == SLI) begin : g_sli
         always_comb begin
            logic [16:0] mdx;
            logic [16:0] mdy;
            pipe_in[k] = pipe_ff[k-1];
            mdx = pipe_ff[k-1].ddx[16] ? 17'(-pipe_ff[k-1].ddx) : 17'(pipe_ff[k-1].ddx);
            mdy = pipe_ff[k-1].ddy[16] ? 17'(-pipe_ff[k-1].ddy) : 17'(pipe_ff[k-1].ddy);
            pipe_in[k].undef = (pipe_ff[k-1].status == ST_OK) &&
                               (pipe_ff[k-1].ddy == 17'sd0);
            pipe_in[k].sneg = pipe_ff[k-1].ddx[16] ^ pipe_ff[k-1].ddy[16];
            pipe_in[k].ovf = ({8'd0, mdx, 8'd0} >= {mdy, 16'd0});
            pipe_in[k].dv0.rem = {27'd0, mdx, 8'd0};
            pipe_in[k].dv0.quo = '0;
            pipe_in[k].den = {17'd0, mdy};
         end
      end else if (k >= SL0 && k < SLF) begin : g_sldiv
         localparam int SH = SLOPE_QW - 1 - (k - SL0);
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].dv0 = div_step(pipe_ff[k-1].dv0, pipe_ff[k-1].den, 5'(SH));
         end
      end else if (k == SLF) begin : g_slf
         always_comb begin
            logic signed [31:0] v;
            pipe_in[k] = pipe_ff[k-1];
            v = $signed({16'd0, pipe_ff[k-1].dv0.quo[15:0]});
            if (pipe_ff[k-1].sneg) begin
               v = -v;
            end
            if (pipe_ff[k-1].status != ST_OK || pipe_ff[k-1].undef) begin
               pipe_in[k].slope = '0;
            end else if (pipe_ff[k-1].ovf) begin
               pipe_in[k].slope = pipe_ff[k-1].sneg ? 16'sh8000 : 16'sh7fff;
            end else begin
               pipe_in[k].slope = sat16(v);
            end
         end
      end else if (k == OPR) begin : g_opr
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            pipe_in[k].prod = pipe_ff[k-1].slope * cfg.camera_y;
         end
      end else begin : g_ofs
         always_comb begin
            logic [31:0]        mp;
            logic signed [31:0] tq;
            pipe_in[k] = pipe_ff[k-1];
            mp = pipe_ff[k-1].prod[31] ? 32'(-pipe_ff[k-1].prod) : 32'(pipe_ff[k-1].prod);
            tq = $signed({8'd0, mp[31:8]});
            if (pipe_ff[k-1].prod[31]) begin
               tq = -tq;
            end
            if (pipe_ff[k-1].status != ST_OK || pipe_ff[k-1].undef) begin
               pipe_in[k].offset = '0;
            end else begin
               pipe_in[k].offset = sat16(32'(cfg.camera_x) - tq);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid               = val_ff[NSTG-1];
   assign out_res.source_x        = pipe_ff[NSTG-1].sx;
   assign out_res.source_y        = pipe_ff[NSTG-1].sy;
   assign out_res.status          = pipe_ff[NSTG-1].status;
   assign out_res.line_slope      = pipe_ff[NSTG-1].slope;
   assign out_res.line_offset     = pipe_ff[NSTG-1].offset;
   assign out_res.slope_undefined = pipe_ff[NSTG-1].undef;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_res.status != ST_OK) |->
         (out_res.source_x == 16'sd0 && out_res.source_y == 16'sd0 &&
          out_res.line_slope == 16'sd0 && out_res.line_offset == 16'sd0 &&
          !out_res.slope_undefined))
      else $error("failed word carries nonzero fields");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_res.slope_undefined) |->
         (out_res.line_slope == 16'sd0 && out_res.line_offset == 16'sd0))
      else $error("undefined slope with nonzero line");

endmodule

// File: src/trsl_outq.sv
module trsl_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  trsl_pkg::res_type in_res,
   output logic              en,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trsl_pkg::res_type rsp_res
);
   import trsl_pkg::*;

   logic    rsp_valid_ff;
   logic    skid_valid_ff;
   res_type rsp_ff;
   res_type skid_ff;
   logic    take;

   assign take = rsp_valid_ff && !rsp_stall;
   assign en   = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_ff <= in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_ff <= in_res;
      end else begin
         skid_ff <= in_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with output register empty");

   a_skid_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall && in_valid))
      else $error("skid filled without a stalled output");

endmodule

// File: src/two_range_source_locator.sv
// Two-range source locator.
// req channel: one word per pair of measured ranges (range_to_first,
// range_to_second, unsigned Q7.8). rsp channel: one word per request with
// source_x/y, status, line_slope, line_offset and slope_undefined.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// rsp_valid rises once a request taken at an edge has passed through 84
// pipeline registers, the first loaded at that edge, and then the output
// register. Throughput is one word per cycle while req_stall is low; the
// long stages are the bit-per-stage dividers and square root.
// The baseline length between the microphones is computed by an iterative
// square root unit: after reset and after any write to a microphone
// register, req_stall stays high while it runs.
// When rsp_stall is high the output register holds its word and a skid
// register takes one more; the pipeline then freezes and req_stall rises.
// Reset clears all valid bits and loads the default geometry.
// Registers (APB, byte address 4*i): mic one x/y, mic two x/y, camera x/y.
module two_range_source_locator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [14:0]        req_range_to_first,
   input  logic [14:0]        req_range_to_second,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_source_x,
   output logic signed [15:0] rsp_source_y,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_line_slope,
   output logic signed [15:0] rsp_line_offset,
   output logic               rsp_slope_undefined,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import trsl_pkg::*;

   localparam logic [2:0] RG_FIRST_MIC_X  = 3'd0;
   localparam logic [2:0] RG_FIRST_MIC_Y  = 3'd1;
   localparam logic [2:0] RG_SECOND_MIC_X = 3'd2;
   localparam logic [2:0] RG_SECOND_MIC_Y = 3'd3;
   localparam logic [2:0] RG_CAMERA_X     = 3'd4;
   localparam logic [2:0] RG_CAMERA_Y     = 3'd5;

   cfg_type    cfg_ff;
   geom_type   geom;
   res_type    core_res;
   res_type    rsp_res;
   logic       core_valid;
   logic       en;
   logic       acc;
   logic       wr;
   logic       mic_wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign mic_wr = wr && (idx == RG_FIRST_MIC_X || idx == RG_FIRST_MIC_Y ||
                          idx == RG_SECOND_MIC_X || idx == RG_SECOND_MIC_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_mic_x  <= 16'sd1280;
         cfg_ff.first_mic_y  <= 16'sd5376;
         cfg_ff.second_mic_x <= 16'sd11520;
         cfg_ff.second_mic_y <= 16'sd11520;
         cfg_ff.camera_x     <= 16'sd1792;
         cfg_ff.camera_y     <= 16'sd9728;
      end else if (wr) begin
         unique case (idx)
            RG_FIRST_MIC_X:  cfg_ff.first_mic_x  <= csr_pwdata[15:0];
            RG_FIRST_MIC_Y:  cfg_ff.first_mic_y  <= csr_pwdata[15:0];
            RG_SECOND_MIC_X: cfg_ff.second_mic_x <= csr_pwdata[15:0];
            RG_SECOND_MIC_Y: cfg_ff.second_mic_y <= csr_pwdata[15:0];
            RG_CAMERA_X:     cfg_ff.camera_x     <= csr_pwdata[15:0];
            RG_CAMERA_Y:     cfg_ff.camera_y     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RG_FIRST_MIC_X:  csr_prdata = {16'd0, cfg_ff.first_mic_x};
         RG_FIRST_MIC_Y:  csr_prdata = {16'd0, cfg_ff.first_mic_y};
         RG_SECOND_MIC_X: csr_prdata = {16'd0, cfg_ff.second_mic_x};
         RG_SECOND_MIC_Y: csr_prdata = {16'd0, cfg_ff.second_mic_y};
         RG_CAMERA_X:     csr_prdata = {16'd0, cfg_ff.camera_x};
         RG_CAMERA_Y:     csr_prdata = {16'd0, cfg_ff.camera_y};
         default:         csr_prdata = '0;
      endcase
   end

   assign req_stall = !en || geom.busy;
   assign acc = req_valid && !req_stall;

   trsl_base u_base (
      .clock (clock),
      .reset (reset),
      .start (mic_wr),
      .cfg   (cfg_ff),
      .geom  (geom)
   );

   trsl_core u_core (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (acc),
      .range_to_first  (req_range_to_first),
      .range_to_second (req_range_to_second),
      .cfg             (cfg_ff),
      .geom            (geom),
      .out_valid       (core_valid),
      .out_res         (core_res)
   );

   trsl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_res    (core_res),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_source_x        = rsp_res.source_x;
   assign rsp_source_y        = rsp_res.source_y;
   assign rsp_status          = rsp_res.status;
   assign rsp_line_slope      = rsp_res.line_slope;
   assign rsp_line_offset     = rsp_res.line_offset;
   assign rsp_slope_undefined = rsp_res.slope_undefined;

endmodule
